### hw/rtl/pd_pkg.sv
`default_nettype none

package pd_pkg;

    localparam logic [7:0] CharPercent   = 8'h25;
    localparam logic [7:0] CharNul       = 8'h00;
    localparam logic [3:0] HexLetterBase = 4'd10;

    // escape phase codes
    localparam logic [1:0] PhIdle    = 2'd0;
    localparam logic [1:0] PhPercent = 2'd1;
    localparam logic [1:0] PhDigit   = 2'd2;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       has_nul;
    } t_out_word;

    // up to three decoded bytes caused by one input character
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            last;
        logic            nul;
    } t_grp;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_of(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= "0" && c <= "9") begin
            h.val = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            h.val = HexLetterBase + 4'(c - "a");
        end else if (c >= "A" && c <= "F") begin
            h.val = HexLetterBase + 4'(c - "A");
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_grp grp_add(input t_grp g, input logic [7:0] b);
        t_grp r;
        r = g;
        case (g.cnt)
            2'd0: begin
                r.bytes[0] = b;
                r.cnt      = 2'd1;
            end
            2'd1: begin
                r.bytes[1] = b;
                r.cnt      = 2'd2;
            end
            2'd2: begin
                r.bytes[2] = b;
                r.cnt      = 2'd3;
            end
            default: begin
            end
        endcase
        if (g.cnt != 2'd3 && b == CharNul) begin
            r.nul = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pd_front.sv
`default_nettype none

module pd_front
    import pd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_take,
    input  wire t_in_word i_word,
    output t_grp          o_grp,
    output logic          o_grp_valid
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_nul, n_nul;

    t_hex hc;
    t_hex hh;
    t_grp g;

    always_comb begin
        hc       = hex_of(i_word.in_char);
        hh       = hex_of(r_held);
        g.cnt    = 2'd0;
        g.bytes  = '0;
        g.last   = i_word.in_last;
        g.nul    = r_nul;
        n_phase  = PhIdle;
        n_held   = r_held;

        case (r_phase)
            PhPercent: begin
                if (hc.ok) begin
                    n_held  = i_word.in_char;
                    n_phase = PhDigit;
                end else begin
                    g = grp_add(g, CharPercent);
                    if (i_word.in_char == CharPercent) n_phase = PhPercent;
                    else g = grp_add(g, i_word.in_char);
                end
            end
            PhDigit: begin
                if (hc.ok && hh.ok) begin
                    g      = grp_add(g, {hh.val, hc.val});
                    n_held = 8'd0;
                end else begin
                    g      = grp_add(g, CharPercent);
                    g      = grp_add(g, r_held);
                    n_held = 8'd0;
                    if (i_word.in_char == CharPercent) n_phase = PhPercent;
                    else g = grp_add(g, i_word.in_char);
                end
            end
            default: begin
                if (i_word.in_char == CharPercent) n_phase = PhPercent;
                else g = grp_add(g, i_word.in_char);
            end
        endcase

        // truncated escape at end of string goes out literally
        if (i_word.in_last) begin
            if (n_phase == PhPercent) begin
                g = grp_add(g, CharPercent);
            end else if (n_phase == PhDigit) begin
                g = grp_add(g, CharPercent);
                g = grp_add(g, n_held);
            end
        end

        n_nul = g.nul;
        if (i_word.in_last) begin
            n_phase = PhIdle;
            n_held  = 8'd0;
            n_nul   = 1'b0;
        end
    end

    assign o_grp       = g;
    assign o_grp_valid = i_take && (g.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhIdle;
            r_held  <= 8'd0;
            r_nul   <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_nul   <= n_nul;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pd_queue.sv
`default_nettype none

module pd_queue
    import pd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_grp i_grp,
    input  wire logic i_rd,
    output t_grp      o_grp,
    output t_q_stat   o_stat
);

    t_grp             r_mem [QDepth];
    logic [QAw-1:0]   r_wp, r_rp;
    logic [QCw-1:0]   r_cnt;
    logic             wr_ok, rd_ok;

    assign o_stat.empty = (r_cnt == QCw'(0));
    assign o_stat.full  = (r_cnt == QCw'(QDepth));
    assign wr_ok        = i_wr && !o_stat.full;
    assign rd_ok        = i_rd && !o_stat.empty;
    assign o_grp        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[r_wp] <= i_grp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) r_wp <= r_wp + QAw'(1);
            if (rd_ok) r_rp <= r_rp + QAw'(1);
            case ({wr_ok, rd_ok})
                2'b10:   r_cnt <= r_cnt + QCw'(1);
                2'b01:   r_cnt <= r_cnt - QCw'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pd_back.sv
`default_nettype none

module pd_back
    import pd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_grp    i_grp,
    input  wire t_q_stat i_stat,
    output logic         o_rd,
    input  wire logic    pop,
    output logic         empty,
    output t_out_word    o_out_word
);

    logic       r_valid;
    t_out_word  r_word;
    logic [1:0] r_idx;
    logic       load;
    logic       final_byte;

    assign load       = !r_valid || pop;
    assign final_byte = (r_idx == (i_grp.cnt - 2'd1));
    assign o_rd       = load && !i_stat.empty && final_byte;
    assign empty      = !r_valid;
    assign o_out_word = r_word;

    always_ff @(posedge i_clk) begin
        if (load && !i_stat.empty) begin
            r_word.out_byte <= i_grp.bytes[r_idx];
            r_word.out_last <= i_grp.last && final_byte;
            r_word.has_nul  <= i_grp.last && final_byte && i_grp.nul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_stat.empty;
            if (!i_stat.empty) begin
                r_idx <= final_byte ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/percent_decoder_core.sv
`default_nettype none

// Streaming URL percent-decoder. Characters of an encoded string come in one
// word per push, with in_last on the final character; decoded bytes leave one
// word per pop, with out_last on the final byte of the string and has_nul set
// there when any decoded byte of the string was zero. "%XY" with two hex
// digits in either case becomes one byte; a broken or truncated escape is
// passed through literally, and a '%' inside it may open a fresh escape. One
// character can be taken every cycle while full is low; a character may
// cause zero to three bytes, and the result side delivers one byte per cycle
// while results are popped, so the sustained rate is set by the number of
// bytes out. A decoded byte is written into the group queue and then into the
// output register before it reaches the result ports. A four-entry group
// queue between the classifier and the byte serializer absorbs expansion;
// full rises only when that queue is full.
module percent_decoder_core
    import pd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_word i_in_word,
    input  wire logic     pop,
    output logic          empty,
    output t_out_word     o_out_word
);

    t_grp    front_grp;     // bytes caused by the current character
    logic    front_valid;   // accepted character made at least one byte
    t_grp    head_grp;      // oldest group waiting for the serializer
    t_q_stat q_stat;
    logic    q_rd;          // serializer finished the head group

    // front: escape tracking and classification, updates on accept
    pd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (push && !full),
        .i_word      (i_in_word),
        .o_grp       (front_grp),
        .o_grp_valid (front_valid)
    );

    // decoupling queue of byte groups
    pd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_grp   (front_grp),
        .i_rd    (q_rd),
        .o_grp   (head_grp),
        .o_stat  (q_stat)
    );

    assign full = q_stat.full;

    // back: walks a group one byte per cycle into the output register while that register is empty or popped
    pd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grp      (head_grp),
        .i_stat     (q_stat),
        .o_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

### hw/rtl/pd_checker.sv
`default_nettype none

module pd_checker
    import pd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      push,
    input wire logic      full,
    input wire t_in_word  i_in_word,
    input wire logic      pop,
    input wire logic      empty,
    input wire t_out_word o_out_word
);

    // nothing waits right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");

    // an accepted word is fully known
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |-> !$isunknown(i_in_word))
        else $error("accepted word has unknown bits");

    // reject flag belongs on the last byte only
    a_nul_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (!o_out_word.has_nul || o_out_word.out_last))
        else $error("has_nul on a byte that is not last");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_word))
        else $error("result word changed while stalled");

endmodule

bind percent_decoder_core pd_checker u_chk (.*);

`default_nettype wire
